// File: design/fxt1_pkg.sv
`timescale 1ns / 1ps
// Shared types, mode codes and channel arithmetic for the FXT1 block decoder.
// No dependencies.
package fxt1_pkg;

  localparam int unsigned BlockW  = 128;
  localparam int unsigned HalfW   = 64;
  localparam int unsigned Entries = 8;
  localparam int unsigned Texels  = 32;
  localparam int unsigned CntW    = $clog2(Texels);
  localparam int unsigned AddrW   = 3;
  localparam logic [7:0]  Opaque  = 8'hff;
  localparam int unsigned Recip3  = 683;   // 2^11 / 3, rounded up
  localparam int unsigned IdxPosW = 7;

  // Mode field, block bits 127:125
  localparam logic [2:0] ModeChroma = 3'd2;
  localparam logic [2:0] ModeAlpha  = 3'd3;

  localparam logic [AddrW-3:0] RegAlphaForce = '0;

  // Channels: [0] red, [1] green, [2] blue, [3] alpha
  typedef logic [3:0][7:0] color_t;
  typedef color_t [Entries-1:0] palette_t;

  function automatic logic [7:0] ex5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] ex6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // floor(x / 3) for x below 768
  function automatic logic [7:0] div3(input logic [10:0] x);
    logic [21:0] m;
    m = 22'(x) * 22'(Recip3);
    return m[18:11];
  endfunction

  // ((6-k)*p + k*q + 3) / 6 on every channel
  function automatic color_t lerp6(input color_t p, input color_t q, input logic [2:0] k);
    color_t r;
    logic [10:0] s;
    for (int c = 0; c < 4; c++) begin
      s = 11'(3'd6 - k) * 11'(p[c]) + 11'(k) * 11'(q[c]) + 11'd3;
      r[c] = div3({1'b0, s[10:1]});
    end
    return r;
  endfunction

  // (2*p + q + 1) / 3 on every channel
  function automatic color_t lerp3(input color_t p, input color_t q);
    color_t r;
    logic [10:0] s;
    for (int c = 0; c < 4; c++) begin
      s = {2'b0, p[c], 1'b0} + 11'(q[c]) + 11'd1;
      r[c] = div3(s);
    end
    return r;
  endfunction

  function automatic color_t half(input color_t p, input color_t q);
    color_t r;
    logic [8:0] s;
    for (int c = 0; c < 4; c++) begin
      s = 9'(p[c]) + 9'(q[c]);
      r[c] = s[8:1];
    end
    return r;
  endfunction

endpackage

// File: design/fxt1_block_decoder.sv
`timescale 1ns / 1ps
// FXT1 block decoder top level: configuration port, texel emitter, output register.
// Depends on fxt1_pkg and fxt1_palette.
//
// Each accepted transaction carries one 128-bit FXT1 block and yields 32 texel
// transactions in row-major order (row 0, columns 0..7 first), with last set on
// the final one. A block passes an endpoint-decode stage and a palette-blend
// stage, then waits in the emitter, which reads one palette entry per cycle
// when the output register is free; it sets the sustained rate. Up to two
// further blocks are accepted while one is being emitted, so with out_stall
// low the output runs without gaps. alpha_force (register 0) is ORed into
// ALPHA-mode endpoint alpha and gives the alpha of transparent entries; write
// it only while idle.
module fxt1_block_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_block_low,
  input  logic [63:0] in_block_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [2:0]  out_column,
  output logic [1:0]  out_row,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [fxt1_pkg::AddrW-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fxt1_pkg::*;

  logic [7:0]         af_r;
  logic               blk_free, pal_valid, pal_take;
  palette_t           pal;
  logic [BlockW-1:0]  pal_blk;

  logic               em_busy_r, em_busy_nxt;
  palette_t           em_pal_r;
  logic [BlockW-1:0]  em_blk_r;
  logic [CntW-1:0]    cnt_r, cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  color_t             out_c_r;
  logic [2:0]         out_col_r;
  logic [1:0]         out_row_r;
  logic               out_last_r;

  logic               out_free, emit, em_done;
  logic [2:0]         col;
  logic [1:0]         row;
  logic [IdxPosW-1:0] pos;
  logic [2:0]         entry;

  // Configuration: pready is fixed high, writes land on the access cycle
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      af_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[AddrW-1:2] == RegAlphaForce) begin
      af_r <= cfg_pwdata[7:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[AddrW-1:2] == RegAlphaForce) ? {24'd0, af_r} : 32'd0;

  // Palette pipeline
  fxt1_palette u_palette (
    .clk         (clk),
    .rst_n       (rst_n),
    .alpha_force (af_r),
    .blk_valid   (in_valid),
    .blk_free    (blk_free),
    .blk         ({in_block_high, in_block_low}),
    .pal_valid   (pal_valid),
    .pal_take    (pal_take),
    .pal         (pal),
    .pal_blk     (pal_blk)
  );
  assign in_stall = !blk_free;

  // Emitter: advance one texel whenever the output register can take it
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = em_busy_r && out_free;
  assign em_done  = emit && (cnt_r == CntW'(Texels - 1));
  assign pal_take = pal_valid && (!em_busy_r || em_done);

  assign col = cnt_r[2:0];
  assign row = cnt_r[4:3];

  // Texel index lookup: 3-bit indices in HI mode, 2-bit plus half select otherwise
  always_comb begin
    if (em_blk_r[127:126] == 2'b00) begin
      pos   = IdxPosW'(48) * IdxPosW'(col[2]) + IdxPosW'(12) * IdxPosW'(row)
            + IdxPosW'(3) * IdxPosW'(col[1:0]);
      entry = em_blk_r[pos +: 3];
    end else begin
      pos   = IdxPosW'(32) * IdxPosW'(col[2]) + IdxPosW'(8) * IdxPosW'(row)
            + IdxPosW'(2) * IdxPosW'(col[1:0]);
      entry = {col[2], em_blk_r[pos +: 2]};
    end
  end

  assign em_busy_nxt   = pal_take || (em_busy_r && !em_done);
  assign cnt_nxt       = emit ? cnt_r + CntW'(1) : cnt_r;
  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_busy_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      em_busy_r   <= em_busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the palette of the block in emission until the next one is taken
  always_ff @(posedge clk) begin
    if (pal_take) begin
      em_pal_r <= pal;
      em_blk_r <= pal_blk;
    end
    if (emit) begin
      out_c_r    <= em_pal_r[entry];
      out_col_r  <= col;
      out_row_r  <= row;
      out_last_r <= (cnt_r == CntW'(Texels - 1));
    end
  end

  assign out_valid  = out_valid_r;
  assign out_red    = out_c_r[0];
  assign out_green  = out_c_r[1];
  assign out_blue   = out_c_r[2];
  assign out_alpha  = out_c_r[3];
  assign out_column = out_col_r;
  assign out_row    = out_row_r;
  assign out_last   = out_last_r;

endmodule

// File: design/fxt1_palette.sv
`timescale 1ns / 1ps
// Two-stage palette builder: endpoint decode, then blends into eight entries.
// Depends on fxt1_pkg.
module fxt1_palette (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [7:0]              alpha_force,
  input  logic                    blk_valid,
  output logic                    blk_free,
  input  logic [fxt1_pkg::BlockW-1:0] blk,
  output logic                    pal_valid,
  input  logic                    pal_take,
  output fxt1_pkg::palette_t      pal,
  output logic [fxt1_pkg::BlockW-1:0] pal_blk
);
  import fxt1_pkg::*;

  logic             s1_valid_r, s1_valid_nxt;
  logic [2:0]       s1_mode_r;
  logic             s1_flag_r;
  color_t [3:0]     s1_c_r, c_nxt;
  logic [BlockW-1:0] s1_blk_r;

  logic             s2_valid_r, s2_valid_nxt;
  palette_t         s2_pal_r, pal_nxt;
  logic [BlockW-1:0] s2_blk_r;

  logic s2_free, s1_adv;
  logic [2:0] mode;
  color_t tr;

  assign s2_free  = !s2_valid_r || pal_take;
  assign s1_adv   = s1_valid_r && s2_free;
  assign blk_free = !s1_valid_r || s2_free;
  assign mode     = blk[127:125];
  assign tr       = {alpha_force, 8'd0, 8'd0, 8'd0};

  // Endpoint decode; pack order is {a, b, g, r}, channel [0] is red
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      c_nxt[k] = {Opaque, ex5(blk[64+15*k +: 5]), ex5(blk[64+15*k+5 +: 5]),
                  ex5(blk[64+15*k+10 +: 5])};
    end
    if (mode[2:1] == 2'b00) begin
      c_nxt[0] = {Opaque, ex5(blk[96 +: 5]), ex5(blk[101 +: 5]), ex5(blk[106 +: 5])};
      c_nxt[1] = {Opaque, ex5(blk[111 +: 5]), ex5(blk[116 +: 5]), ex5(blk[121 +: 5])};
    end else if (mode == ModeAlpha) begin
      for (int k = 0; k < 3; k++) begin
        c_nxt[k][3] = ex5(blk[109+5*k +: 5]) | alpha_force;
      end
    end else if (mode[2]) begin
      c_nxt[1][1] = ex6({blk[84 +: 5], blk[125]});
      c_nxt[3][1] = ex6({blk[114 +: 5], blk[126]});
      if (!blk[124]) begin
        c_nxt[0][1] = ex6({blk[69 +: 5], blk[125] ^ blk[1]});
        c_nxt[2][1] = ex6({blk[99 +: 5], blk[126] ^ blk[33]});
      end
    end
  end

  // Palette blends
  always_comb begin
    pal_nxt = '0;
    if (s1_mode_r[2:1] == 2'b00) begin
      for (int k = 0; k < 7; k++) begin
        pal_nxt[k] = lerp6(s1_c_r[0], s1_c_r[1], 3'(k));
      end
      pal_nxt[7] = tr;
    end else if (s1_mode_r == ModeChroma) begin
      for (int k = 0; k < 4; k++) begin
        pal_nxt[k]   = s1_c_r[k];
        pal_nxt[k+4] = s1_c_r[k];
      end
    end else if (s1_mode_r == ModeAlpha) begin
      if (!s1_flag_r) begin
        for (int k = 0; k < 3; k++) begin
          pal_nxt[k]   = s1_c_r[k];
          pal_nxt[k+4] = s1_c_r[k];
        end
        pal_nxt[3] = tr;
        pal_nxt[7] = tr;
      end else begin
        pal_nxt[0] = s1_c_r[0];
        pal_nxt[1] = lerp3(s1_c_r[0], s1_c_r[1]);
        pal_nxt[2] = lerp3(s1_c_r[1], s1_c_r[0]);
        pal_nxt[3] = s1_c_r[1];
        pal_nxt[4] = s1_c_r[2];
        pal_nxt[5] = lerp3(s1_c_r[2], s1_c_r[1]);
        pal_nxt[6] = lerp3(s1_c_r[1], s1_c_r[2]);
        pal_nxt[7] = s1_c_r[1];
      end
    end else begin
      for (int h = 0; h < 2; h++) begin
        pal_nxt[4*h] = s1_c_r[2*h];
        if (!s1_flag_r) begin
          pal_nxt[4*h+1] = lerp3(s1_c_r[2*h], s1_c_r[2*h+1]);
          pal_nxt[4*h+2] = lerp3(s1_c_r[2*h+1], s1_c_r[2*h]);
          pal_nxt[4*h+3] = s1_c_r[2*h+1];
        end else begin
          pal_nxt[4*h+1] = half(s1_c_r[2*h], s1_c_r[2*h+1]);
          pal_nxt[4*h+2] = s1_c_r[2*h+1];
          pal_nxt[4*h+3] = tr;
        end
      end
    end
  end

  assign s1_valid_nxt = blk_valid || (s1_valid_r && !s2_free);
  assign s2_valid_nxt = s1_adv || (s2_valid_r && !pal_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= blk_free ? s1_valid_nxt : s1_valid_r;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_valid && blk_free) begin
      s1_mode_r <= mode;
      s1_flag_r <= blk[124];
      s1_blk_r  <= blk;
      s1_c_r    <= c_nxt;
    end
    if (s1_adv) begin
      s2_pal_r <= pal_nxt;
      s2_blk_r <= s1_blk_r;
    end
  end

  assign pal_valid = s2_valid_r;
  assign pal       = s2_pal_r;
  assign pal_blk   = s2_blk_r;

endmodule

// File: bench/fxt1_block_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the FXT1 block decoder: directed blocks, then random ones.
// Depends on fxt1_pkg and the fxt1_block_decoder RTL.
module fxt1_block_decoder_tb;
  import fxt1_pkg::*;

  localparam int IdleLimit = 4000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [2:0] column;
    logic [1:0] row;
    logic       last;
  } texel_t;

  int errors = 0;

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Texel predictor and store of expected texels.
  class texel_scoreboard;
    logic [7:0]   alpha_force;
    logic [127:0] blk;
    logic [31:0]  pal [8];
    texel_t       pending [$];

    function logic [31:0] bits(input int pos, input int n);
      logic [127:0] v;
      v = blk >> pos;
      return v[31:0] & ((32'd1 << n) - 1);
    endfunction

    function logic [7:0] x5(input logic [4:0] v);
      return {v, v[4:2]};
    endfunction

    function logic [7:0] x6(input logic [5:0] v);
      return {v, v[5:4]};
    endfunction

    function logic [31:0] rgba(input logic [7:0] r, g, b, a);
      return {a, b, g, r};
    endfunction

    // Per channel (wp*p + wq*q + add) / div.
    function logic [31:0] mix(input logic [31:0] p, q, input int wp, wq, add, dv);
      logic [31:0] res;
      int s;
      for (s = 0; s < 32; s += 8) res[s+:8] = (wp * p[s+:8] + wq * q[s+:8] + add) / dv;
      return res;
    endfunction

    function logic [31:0] endpt(input int n, input logic [7:0] a);
      int base;
      base = 64 + 15 * n;
      return rgba(x5(bits(base + 10, 5)), x5(bits(base + 5, 5)), x5(bits(base, 5)), a);
    endfunction

    function void build(input logic [2:0] mode);
      logic [31:0] tr, c0, c1, p, q;
      logic [31:0] c [4];
      logic l1, l3;
      int k;
      tr = rgba(0, 0, 0, alpha_force);
      if (mode <= 3'd1) begin
        c0 = rgba(x5(bits(106, 5)), x5(bits(101, 5)), x5(bits(96, 5)), Opaque);
        c1 = rgba(x5(bits(121, 5)), x5(bits(116, 5)), x5(bits(111, 5)), Opaque);
        for (k = 0; k < 7; k++) pal[k] = mix(c0, c1, 6 - k, k, 3, 6);
        pal[7] = tr;
      end else if (mode == ModeChroma) begin
        for (k = 0; k < 4; k++) begin
          pal[k] = endpt(k, Opaque);
          pal[k+4] = pal[k];
        end
      end else if (mode == ModeAlpha) begin
        for (k = 0; k < 3; k++) c[k] = endpt(k, x5(bits(109 + 5 * k, 5)) | alpha_force);
        if (!bits(124, 1)) begin
          for (k = 0; k < 3; k++) begin
            pal[k] = c[k];
            pal[k+4] = c[k];
          end
          pal[3] = tr;
          pal[7] = tr;
        end else begin
          pal[0] = c[0];
          pal[1] = mix(c[0], c[1], 2, 1, 1, 3);
          pal[2] = mix(c[0], c[1], 1, 2, 1, 3);
          pal[3] = c[1];
          pal[4] = c[2];
          pal[5] = mix(c[2], c[1], 2, 1, 1, 3);
          pal[6] = mix(c[2], c[1], 1, 2, 1, 3);
          pal[7] = c[1];
        end
      end else begin
        l1 = blk[125];
        l3 = blk[126];
        for (k = 0; k < 4; k++) c[k] = endpt(k, Opaque);
        c[1][15:8] = x6({5'(bits(84, 5)), l1});
        c[3][15:8] = x6({5'(bits(114, 5)), l3});
        if (!bits(124, 1)) begin
          c[0][15:8] = x6({5'(bits(69, 5)), l1 ^ blk[1]});
          c[2][15:8] = x6({5'(bits(99, 5)), l3 ^ blk[33]});
          for (k = 0; k < 2; k++) begin
            p = c[2*k];
            q = c[2*k+1];
            pal[4*k]   = p;
            pal[4*k+1] = mix(p, q, 2, 1, 1, 3);
            pal[4*k+2] = mix(p, q, 1, 2, 1, 3);
            pal[4*k+3] = q;
          end
        end else begin
          for (k = 0; k < 2; k++) begin
            p = c[2*k];
            q = c[2*k+1];
            pal[4*k]   = p;
            pal[4*k+1] = mix(p, q, 1, 1, 0, 2);
            pal[4*k+2] = q;
            pal[4*k+3] = tr;
          end
        end
      end
    endfunction

    // Note an accepted block: queue its 32 texels.
    function void note_block(input logic [63:0] lo, hi);
      logic [2:0] mode;
      int n, row, col, x, rt, idx;
      texel_t t;
      blk = {hi, lo};
      mode = hi[63:61];
      build(mode);
      for (n = 0; n < 32; n++) begin
        row = n / 8;
        col = n % 8;
        x = col % 4;
        rt = col / 4;
        if (mode <= 3'd1) idx = bits(48 * rt + 12 * row + 3 * x, 3);
        else idx = 4 * rt + bits(32 * rt + 8 * row + 2 * x, 2);
        t.red = pal[idx][7:0];
        t.green = pal[idx][15:8];
        t.blue = pal[idx][23:16];
        t.alpha = pal[idx][31:24];
        t.column = col;
        t.row = row;
        t.last = (n == 31);
        pending.push_back(t);
      end
    endfunction

    // Compare one texel against the oldest expectation.
    task check_texel(input texel_t got);
      texel_t e;
      if (pending.size() == 0) begin
        report_mismatch("texel with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (got.red != e.red) report_mismatch($sformatf("red %0h exp %0h", got.red, e.red));
      if (got.green != e.green)
        report_mismatch($sformatf("green %0h exp %0h", got.green, e.green));
      if (got.blue != e.blue) report_mismatch($sformatf("blue %0h exp %0h", got.blue, e.blue));
      if (got.alpha != e.alpha)
        report_mismatch($sformatf("alpha %0h exp %0h", got.alpha, e.alpha));
      if (got.column != e.column)
        report_mismatch($sformatf("column %0d exp %0d", got.column, e.column));
      if (got.row != e.row) report_mismatch($sformatf("row %0d exp %0d", got.row, e.row));
      if (got.last != e.last) report_mismatch($sformatf("last %0b exp %0b", got.last, e.last));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [63:0] in_block_low = '0;
  logic [63:0] in_block_high = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;
  logic [2:0]  out_column;
  logic [1:0]  out_row;
  logic        out_last;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [AddrW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  texel_scoreboard sb = new();
  bit   calm = 0;       // set in the last part of the run: no idling
  int   idle_cycles = 0;

  always #5 clk = ~clk;

  fxt1_block_decoder u_top (.*);

  // Watchdog: count cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sample texel transactions at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_texel({out_red, out_green, out_blue, out_alpha, out_column, out_row, out_last});
  end

  // Receiver stalls in random bursts; drop them in the last part of the run.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 18);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  // Register write: setup, then access.
  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
  endtask

  // Offer one block and hold it until accepted, with an optional gap first.
  task automatic send_block(input logic [63:0] lo, hi);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_block_low <= lo;
    in_block_high <= hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_block(lo, hi);
    @(negedge clk);
  endtask

  // Wait for every expected texel, then let the pipeline settle.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_alpha_force(input logic [7:0] v);
    write_reg(RegAlphaForce, {24'd0, v});
    sb.alpha_force = v;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random block: mode drawn evenly over the four modes, other bits random.
  function automatic logic [63:0] rand_high();
    logic [63:0] h;
    h = rand64();
    case ($urandom_range(0, 3))
      0: h[63:62] = 2'b00;
      1: h[63:61] = ModeChroma;
      2: h[63:61] = ModeAlpha;
      default: h[63] = 1'b1;
    endcase
    return h;
  endfunction

  initial begin
    logic [7:0] settings [4] = '{8'h00, 8'hff, 8'h5a, 8'h81};
    int i, p;
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: each mode and sub-mode, with all-zero, all-one and patterned fields.
    set_alpha_force(8'h00);
    send_block('0, '0);
    send_block('1, '1);
    send_block('1, {ModeChroma, 61'h0});
    send_block('1, {ModeChroma, 61'h1fff_ffff_ffff_ffff});
    send_block('1, {ModeAlpha, 1'b0, 60'h0aa5_5aa5_5aa5_5aa5});
    send_block('1, {ModeAlpha, 1'b1, 60'h0ff0_0ff0_0ff0_0ff0});
    send_block(64'h0000_0002_0000_0002, {3'b100, 61'h0});
    send_block(64'h0, {3'b111, 1'b0, 60'hfff_ffff_ffff_ffff});
    send_block(64'h5555_5555_5555_5555, {3'b101, 1'b1, 60'h123_4567_89ab_cdef});
    send_block(64'haaaa_aaaa_aaaa_aaaa, {3'b110, 1'b1, 60'h0});
    send_block(64'h0123_4567_89ab_cdef, {3'b001, 61'h1357_9bdf_0246_8ace});
    send_block(64'hffff_ffff_0000_0000, {ModeAlpha, 1'b0, 60'h0});
    drain();
    set_alpha_force(8'hff);
    send_block('1, {ModeAlpha, 1'b0, 60'h0});
    send_block('1, {3'b111, 1'b1, 60'h0});
    send_block('1, {3'b000, 61'h0});
    drain();

    // Random phases across several alpha_force settings; last one is calm.
    for (p = 0; p < 4; p++) begin
      set_alpha_force(p == 3 ? 8'($urandom()) : settings[p]);
      if (p == 3) calm = 1;
      for (i = 0; i < 100; i++) send_block(rand64(), rand_high());
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// File: fxt1_block_decoder.f
design/fxt1_pkg.sv
design/fxt1_palette.sv
design/fxt1_block_decoder.sv
bench/fxt1_block_decoder_tb.sv
